// ===== rtl/core/tdpf_pkg.sv =====
// tdpf_pkg: shared constants for the trial division prime filter
// no dependencies

package tdpf_pkg;

	// width of the tested value, sign at the top bit
	localparam int VALUE_BITS = 32;

	// width of the bit counter of the shared divider
	localparam int CNT_BITS = $clog2(VALUE_BITS);

	// first trial divisor
	localparam logic [VALUE_BITS-1:0] SMALLEST_PRIME = VALUE_BITS'(2);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

endpackage

// ===== rtl/core/trial_division_prime_filter.sv =====
// trial_division_prime_filter: primality test by trial division, one shared
// restoring divider under a small sequencer. depends on tdpf_pkg.
//
// negative values and values below 2 are answered from idle without division;
// else each trial divisor k takes 32 divider steps plus one check, with
// k = 2 .. floor(sqrt(value)) + 1 at most; those early answers never raise busy.
// one word at a time: busy stays high until the result strobe (done) fires.
// done is a one-cycle pulse; the receiver cannot stall it.
// arst_n clears the sequencer and the strobe; data registers are not reset.

module trial_division_prime_filter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] value,
	input  logic        last_element,
	output logic        done,
	output logic signed [31:0] tested_value,
	output logic        is_prime,
	output logic        last_result
);

	localparam int VB = tdpf_pkg::VALUE_BITS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0]           state_q;
	tdpf_pkg::value_t     v_q;       // value under test
	tdpf_pkg::value_t     k_q;       // current trial divisor
	tdpf_pkg::value_t     dq_q;      // dividend shifting out, quotient shifting in
	logic [VB:0]          rem_q;     // partial remainder
	tdpf_pkg::cnt_t       cnt_q;
	logic                 last_q;
	logic                 done_q;
	logic                 prime_q;
	logic signed [31:0]   out_val_q;
	logic                 out_last_q;

	// one restoring step of the shared divider
	logic [VB:0] trial_rem;
	logic [VB:0] diff;
	logic        fits;

	assign trial_rem = {rem_q[VB-1:0], dq_q[VB-1]};
	assign diff      = trial_rem - {1'b0, k_q};
	assign fits      = trial_rem >= {1'b0, k_q};

	// input word viewed at the value width, upper bits zero when wider
	tdpf_pkg::value_t in_v;
	assign in_v = tdpf_pkg::value_t'($unsigned(value));

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign tested_value = out_val_q;
	assign is_prime     = prime_q;
	assign last_result  = out_last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (in_v[VB-1] || (in_v < tdpf_pkg::SMALLEST_PRIME)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == tdpf_pkg::cnt_t'(VB - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if ((k_q > dq_q) || (rem_q == '0)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: divider registers, divisor and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					v_q        <= in_v;
					k_q        <= tdpf_pkg::SMALLEST_PRIME;
					dq_q       <= in_v;
					rem_q      <= '0;
					cnt_q      <= '0;
					last_q     <= last_element;
					out_val_q  <= value;
					out_last_q <= last_element;
					prime_q    <= 1'b0;
				end
			end
			ST_DIV: begin
				dq_q  <= {dq_q[VB-2:0], fits};
				rem_q <= fits ? diff : trial_rem;
				cnt_q <= cnt_q + 1'b1;
			end
			ST_CHECK: begin
				// k past the root bound: prime; exact divide: composite
				if (k_q > dq_q) begin
					prime_q    <= 1'b1;
					out_last_q <= last_q;
				end else if (rem_q == '0) begin
					prime_q    <= 1'b0;
					out_last_q <= last_q;
				end else begin
					k_q   <= k_q + 1'b1;
					dq_q  <= v_q;
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
